// ===== hw/rtl/ntc_pkg.sv =====
package ntc_pkg;

  // Source operand types.
  localparam logic [1:0] SRC_I8  = 2'd0;
  localparam logic [1:0] SRC_I32 = 2'd1;
  localparam logic [1:0] SRC_I64 = 2'd2;
  localparam logic [1:0] SRC_F64 = 2'd3;

  // Target types.
  localparam logic [3:0] TGT_I8  = 4'd0;
  localparam logic [3:0] TGT_U8  = 4'd1;
  localparam logic [3:0] TGT_I16 = 4'd2;
  localparam logic [3:0] TGT_U16 = 4'd3;
  localparam logic [3:0] TGT_I32 = 4'd4;
  localparam logic [3:0] TGT_U32 = 4'd5;
  localparam logic [3:0] TGT_I64 = 4'd6;
  localparam logic [3:0] TGT_U64 = 4'd7;
  localparam logic [3:0] TGT_F32 = 4'd8;
  localparam logic [3:0] TGT_F64 = 4'd9;
  localparam logic [3:0] TGT_PTR = 4'd10;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  function automatic logic [3:0] tgt_size(input logic [3:0] tgt);
    logic [3:0] sz;
    case (tgt)
      TGT_I8, TGT_U8:            sz = 4'd1;
      TGT_I16, TGT_U16:          sz = 4'd2;
      TGT_I32, TGT_U32, TGT_F32: sz = 4'd4;
      default:                   sz = 4'd8;
    endcase
    return sz;
  endfunction

  function automatic logic [3:0] src_size(input logic [1:0] src);
    logic [3:0] sz;
    case (src)
      SRC_I8:  sz = 4'd1;
      SRC_I32: sz = 4'd4;
      default: sz = 4'd8;
    endcase
    return sz;
  endfunction

endpackage

// ===== hw/rtl/ntc_in_if.sv =====
interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  source_type;
  logic [3:0]  target_type;
  logic [63:0] operand_bits;

  modport source (output valid, source_type, target_type, operand_bits, input ready);
  modport sink   (input valid, source_type, target_type, operand_bits, output ready);
endinterface

// ===== hw/rtl/ntc_out_if.sv =====
interface ntc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_bits;
  logic [3:0]  popped_bytes;
  logic [3:0]  pushed_bytes;
  logic [1:0]  status;

  modport source (output valid, result_bits, popped_bytes, pushed_bytes, status,
                  input ready);
  modport sink   (input valid, result_bits, popped_bytes, pushed_bytes, status,
                  output ready);
endinterface

// ===== hw/rtl/numeric_type_converter.sv =====
// Channel   Modport  Beat contents
// in_bus    sink     source_type, target_type, operand_bits
// out_bus   source   result_bits, popped_bytes, pushed_bytes, status
//
// One beat is accepted per cycle while in_bus.ready is high; each accepted beat
// is captured in the input register, then its result in the result register.
// A single combinational conversion pass lies between those registers.
// Reset (rst_n low, synchronous) empties both stages; payload is not cleared.
// A stalled output holds its beat, and the input stage still fills behind it.
module numeric_type_converter
  import ntc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ntc_in_if.sink    in_bus,
  ntc_out_if.source out_bus
);

  logic        s1_v_r;
  logic [1:0]  s1_src_r;
  logic [3:0]  s1_tgt_r;
  logic [63:0] s1_op_r;

  logic        out_v_r;
  logic [63:0] out_res_r;
  logic [3:0]  out_pop_r, out_push_r;
  logic [1:0]  out_st_r;

  logic [63:0] res_nxt;
  logic [3:0]  pop_nxt, push_nxt;
  logic [1:0]  st_nxt;
  logic        out_adv, s1_adv;

  // The result register advances when empty or when its beat is taken;
  // the input register advances whenever its contents can move on.
  assign out_adv       = !out_v_r || out_bus.ready;
  assign s1_adv        = !s1_v_r || out_adv;
  assign in_bus.ready  = s1_adv;

  ntc_conv u_conv (
    .src    (s1_src_r),
    .tgt    (s1_tgt_r),
    .op     (s1_op_r),
    .res    (res_nxt),
    .popped (pop_nxt),
    .pushed (push_nxt),
    .status (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_bus.valid;
      if (out_adv) out_v_r <= s1_v_r;
    end
    if (s1_adv && in_bus.valid) begin
      s1_src_r <= in_bus.source_type;
      s1_tgt_r <= in_bus.target_type;
      s1_op_r  <= in_bus.operand_bits;
    end
    if (out_adv && s1_v_r) begin
      out_res_r  <= res_nxt;
      out_pop_r  <= pop_nxt;
      out_push_r <= push_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.result_bits  = out_res_r;
  assign out_bus.popped_bytes = out_pop_r;
  assign out_bus.pushed_bytes = out_push_r;
  assign out_bus.status       = out_st_r;

endmodule

// ===== hw/rtl/ntc_conv.sv =====
module ntc_conv
  import ntc_pkg::*;
(
  input  logic [1:0]  src,
  input  logic [3:0]  tgt,
  input  logic [63:0] op,
  output logic [63:0] res,
  output logic [3:0]  popped,
  output logic [3:0]  pushed,
  output logic [1:0]  status
);

  logic        unknown, identity;
  logic [63:0] v, m, n;
  logic        sgn;
  logic [5:0]  e;
  logic [53:0] d_mant;
  logic [24:0] s_mant;
  logic        d_up, s_up;
  logic [63:0] i2f_d, i2f_s;

  logic [10:0] fe;
  logic [51:0] ffrac;
  logic [52:0] fm;
  logic        fs;
  logic [63:0] mag, fmask, pos_max, neg_max, f2i;
  logic        huge, is_nan, tsigned;
  logic [1:0]  f2i_st;
  logic [5:0]  k;

  logic [24:0] n_mant;
  logic [10:0] eb;
  logic [5:0]  sh;
  logic [52:0] q, rem_lo;
  logic        g, up;
  logic [31:0] d2s;

  // Integer source, sign-extended to 64 bits.
  always_comb begin
    case (src)
      SRC_I8:  v = {{56{op[7]}}, op[7:0]};
      SRC_I32: v = {{32{op[31]}}, op[31:0]};
      default: v = op;
    endcase
  end

  // Integer to float: normalize so the leading one sits at bit 63, then round.
  always_comb begin
    sgn = v[63];
    m   = sgn ? (64'd0 - v) : v;
    e   = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) e = 6'(i);
    end
    n      = m << (6'd63 - e);
    d_up   = n[10] && ((|n[9:0]) || n[11]);
    s_up   = n[39] && ((|n[38:0]) || n[40]);
    d_mant = {1'b0, n[63:11]} + 54'(d_up);
    s_mant = {1'b0, n[63:40]} + 25'(s_up);
    i2f_d  = {sgn, 11'(11'd1023 + 11'(e) + 11'(d_mant[53])),
              d_mant[53] ? 52'd0 : d_mant[51:0]};
    i2f_s  = {32'd0, sgn, 8'(8'd127 + 8'(e) + 8'(s_mant[24])),
              s_mant[24] ? 23'd0 : s_mant[22:0]};
    if (v == 64'd0) begin
      i2f_d = 64'd0;
      i2f_s = 64'd0;
    end
  end

  // f64 to integer: truncate toward zero, saturate out of range, zero for NaN.
  always_comb begin
    fs      = op[63];
    fe      = op[62:52];
    ffrac   = op[51:0];
    fm      = {1'b1, ffrac};
    is_nan  = (fe == 11'h7FF) && (ffrac != 52'd0);
    huge    = (fe >= 11'd1087);
    k       = 6'(fe - 11'd1023);
    mag     = 64'd0;
    if (fe >= 11'd1023 && !huge) begin
      if (k >= 6'd52) mag = {11'd0, fm} << (k - 6'd52);
      else            mag = {11'd0, fm} >> (6'd52 - k);
    end
    case (tgt_size(tgt))
      4'd1:    fmask = 64'hFF;
      4'd2:    fmask = 64'hFFFF;
      4'd4:    fmask = 64'hFFFF_FFFF;
      default: fmask = '1;
    endcase
    tsigned = !tgt[0];
    pos_max = tsigned ? (fmask >> 1) : fmask;
    neg_max = tsigned ? ((fmask >> 1) + 64'd1) : 64'd0;
    f2i_st  = ST_OK;
    if (is_nan) begin
      f2i    = 64'd0;
      f2i_st = ST_SAT;
    end else if (!fs) begin
      if (huge || mag > pos_max) begin
        f2i    = pos_max;
        f2i_st = ST_SAT;
      end else begin
        f2i = mag & fmask;
      end
    end else if (huge || mag > neg_max) begin
      f2i    = (64'd0 - neg_max) & fmask;
      f2i_st = ST_SAT;
    end else begin
      f2i = (64'd0 - mag) & fmask;
    end
  end

  // f64 to f32, round to nearest even, with subnormal results.
  always_comb begin
    n_mant = 25'd0;
    eb     = 11'd0;
    sh     = 6'd0;
    q      = 53'd0;
    rem_lo = 53'd0;
    g      = 1'b0;
    up     = 1'b0;
    if (fe == 11'h7FF) begin
      d2s = (ffrac != 52'd0) ? {fs, 31'h7FC0_0000 | 31'(ffrac >> 29)}
                             : {fs, 31'h7F80_0000};
    end else if (fe == 11'd0) begin
      d2s = {fs, 31'd0};
    end else if (fe >= 11'd897) begin
      up     = fm[28] && ((|fm[27:0]) || fm[29]);
      n_mant = {1'b0, fm[52:29]} + 25'(up);
      eb     = (fe - 11'd896) + 11'(n_mant[24]);
      if (eb >= 11'd255) d2s = {fs, 31'h7F80_0000};
      else d2s = {fs, eb[7:0], n_mant[24] ? 23'd0 : n_mant[22:0]};
    end else if (fe <= 11'd862) begin
      d2s = {fs, 31'd0};
    end else begin
      // Shift amount runs from 30 to 63 here; a guard bit above the
      // mantissa is zero.
      sh     = 6'(11'd926 - fe);
      q      = fm >> sh;
      g      = (sh <= 6'd53) ? fm[6'(sh - 6'd1)] : 1'b0;
      rem_lo = fm & ((53'd1 << (sh - 6'd1)) - 53'd1);
      up     = g && ((rem_lo != 53'd0) || q[0]);
      d2s    = {fs, 31'(q + 53'(up))};
    end
  end

  always_comb begin
    unknown  = (tgt > TGT_PTR) || (src == SRC_I8 && tgt != TGT_I16)
               || (src == SRC_F64 && tgt == TGT_PTR);
    identity = (src == SRC_I32 && tgt == TGT_I32) || (src == SRC_I64 && tgt == TGT_I64)
               || (src == SRC_F64 && tgt == TGT_F64);
    res    = 64'd0;
    popped = 4'd0;
    pushed = 4'd0;
    status = ST_OK;
    if (unknown) begin
      status = ST_HALT;
    end else if (identity) begin
      res = op;
    end else begin
      popped = src_size(src);
      pushed = tgt_size(tgt);
      if (src == SRC_F64) begin
        if (tgt == TGT_F32) begin
          res = {32'd0, d2s};
        end else begin
          res    = f2i;
          status = f2i_st;
        end
      end else if (tgt == TGT_F32) begin
        res = i2f_s;
      end else if (tgt == TGT_F64) begin
        res = i2f_d;
      end else begin
        case (tgt_size(tgt))
          4'd1:    res = {56'd0, v[7:0]};
          4'd2:    res = {48'd0, v[15:0]};
          4'd4:    res = {32'd0, v[31:0]};
          default: res = v;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/ntc_checker.sv =====
module ntc_checker
  import ntc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_bits,
  input logic [3:0]  out_popped_bytes,
  input logic [3:0]  out_pushed_bytes,
  input logic [1:0]  out_status
);

  // A halt reports nothing popped, pushed or produced.
  a_halt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HALT |->
      out_popped_bytes == 4'd0 && out_pushed_bytes == 4'd0 && out_result_bits == 64'd0)
    else $error("halt beat carries data");

  // Identity beats pop and push nothing; real conversions do both.
  a_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_popped_bytes == 4'd0) == (out_pushed_bytes == 4'd0)))
    else $error("popped and pushed disagree");

  // Saturation only comes from a float source of eight bytes.
  a_sat_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |-> out_popped_bytes == 4'd8)
    else $error("saturation from integer source");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits)
      && $stable(out_status))
    else $error("stalled beat changed");

endmodule

bind numeric_type_converter ntc_checker u_ntc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_result_bits  (out_bus.result_bits),
  .out_popped_bytes (out_bus.popped_bytes),
  .out_pushed_bytes (out_bus.pushed_bytes),
  .out_status       (out_bus.status)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the numeric type converter.
// A directed table covers the type pairs, identity and unknown pairs, float
// corner values and saturation; random beats follow. Each result beat is
// compared with a typed-in value or one computed here from operand bits.
module testbench;
  import ntc_pkg::*;

  typedef struct packed {
    logic [1:0]  src;
    logic [3:0]  tgt;
    logic [63:0] op;
  } conv_req_t;

  typedef struct packed {
    logic [63:0] bits;
    logic [3:0]  popped;
    logic [3:0]  pushed;
    logic [1:0]  status;
  } conv_res_t;

  // A directed row: the request, plus an optional typed-in result.
  typedef struct packed {
    conv_req_t req;
    logic      has_fixed;
    conv_res_t fixed;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1300;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   error_count;
  bit   stim_done;

  ntc_in_if  in_bus ();
  ntc_out_if out_bus ();

  numeric_type_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  conv_res_t pending_results[$];
  dir_row_t  dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mask of the low w bits, w in 1..64.
  function automatic logic [63:0] width_mask(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Right shift with round to nearest even.
  function automatic logic [63:0] rne_shift(input logic [63:0] m, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (sh == 0) return m;
    if (sh >= 64) return 64'd0;
    q = m >> sh;
    rem = m & width_mask(sh);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Signed 64-bit integer to f32 (dbl = 0) or f64 (dbl = 1) bits.
  function automatic logic [63:0] signed_to_float(input logic [63:0] v, input bit dbl);
    int          prec;
    int          bias;
    int          msb;
    logic        sgn;
    logic [63:0] mag;
    logic [63:0] mant;
    prec = dbl ? 53 : 24;
    bias = dbl ? 1023 : 127;
    sgn = v[63];
    mag = sgn ? -v : v;
    if (v == 64'd0) return 64'd0;
    msb = 63;
    while (!mag[msb]) msb--;
    if (msb <= prec - 1) begin
      mant = mag << (prec - 1 - msb);
    end else begin
      mant = rne_shift(mag, msb - (prec - 1));
      if ((mant >> prec) != 64'd0) begin
        mant = mant >> 1;
        msb++;
      end
    end
    return (64'(sgn) << (dbl ? 63 : 31)) | (64'(msb + bias) << (prec - 1))
           | (mant & width_mask(prec - 1));
  endfunction

  // f64 to an integer target: truncate toward zero, saturate, NaN gives zero.
  function automatic logic [63:0] double_to_integer(input logic [63:0] bits,
                                                    input logic [3:0] tgt,
                                                    output logic [1:0] status);
    int          w;
    int          k;
    bit          is_signed;
    bit          huge;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [63:0] mask;
    logic [63:0] pos_max;
    logic [63:0] neg_max;
    logic [63:0] mag;
    logic [63:0] mant;
    w = 8 * int'(tgt_size(tgt));
    is_signed = !tgt[0];
    ex = bits[62:52];
    frac = bits[51:0];
    mask = width_mask(w);
    pos_max = is_signed ? (mask >> 1) : mask;
    neg_max = is_signed ? (64'd1 << (w - 1)) : 64'd0;
    mag = 64'd0;
    huge = 1'b0;
    status = ST_OK;
    if (ex == 11'h7FF && frac != 52'd0) begin
      status = ST_SAT;
      return 64'd0;
    end
    if (ex == 11'h7FF) begin
      huge = 1'b1;
    end else if (ex >= 11'd1023) begin
      k = int'(ex) - 1023;
      mant = {12'd1, frac};
      if (k >= 64) huge = 1'b1;
      else if (k >= 52) mag = mant << (k - 52);
      else mag = mant >> (52 - k);
    end
    if (!bits[63]) begin
      if (huge || mag > pos_max) begin
        status = ST_SAT;
        return pos_max;
      end
      return mag & mask;
    end
    if (huge || mag > neg_max) begin
      status = ST_SAT;
      return (-neg_max) & mask;
    end
    return (-mag) & mask;
  endfunction

  // f64 to f32 with round to nearest even.
  function automatic logic [63:0] narrow_double(input logic [63:0] bits);
    logic [63:0] sgn;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [63:0] mant;
    int          eb;
    sgn = 64'(bits[63]) << 31;
    ex = bits[62:52];
    frac = bits[51:0];
    if (ex == 11'h7FF) begin
      if (frac != 52'd0) return sgn | 64'h7FC0_0000 | (64'(frac) >> 29);
      return sgn | 64'h7F80_0000;
    end
    // f64 subnormals lie far below the f32 range.
    if (ex == 11'd0) return sgn;
    eb = int'(ex) - 1023 + 127;
    if (eb >= 1) begin
      mant = rne_shift({12'd1, frac}, 29);
      if (mant[24]) begin
        mant = mant >> 1;
        eb++;
      end
      if (eb >= 255) return sgn | 64'h7F80_0000;
      return sgn | (64'(eb) << 23) | (mant & width_mask(23));
    end
    // A rounding carry into bit 23 lands on the smallest normal by itself.
    return sgn | rne_shift({12'd1, frac}, 30 - eb);
  endfunction

  function automatic logic [3:0] src_size_of(input logic [1:0] s);
    case (s)
      SRC_I8:  return 4'd1;
      SRC_I32: return 4'd4;
      default: return 4'd8;
    endcase
  endfunction

  function automatic conv_res_t convert(input conv_req_t r);
    conv_res_t   res;
    logic [63:0] v;
    logic [1:0]  st;
    res = '0;
    if (r.tgt > TGT_PTR || (r.src == SRC_I8 && r.tgt != TGT_I16)
        || (r.src == SRC_F64 && r.tgt == TGT_PTR)) begin
      res.status = ST_HALT;
    end else if ((r.src == SRC_I32 && r.tgt == TGT_I32) || (r.src == SRC_I64 && r.tgt == TGT_I64)
                 || (r.src == SRC_F64 && r.tgt == TGT_F64)) begin
      // Identity pairs leave the stack untouched.
      res.bits = r.op;
    end else begin
      res.popped = src_size_of(r.src);
      res.pushed = tgt_size(r.tgt);
      if (r.src == SRC_F64) begin
        if (r.tgt == TGT_F32) begin
          res.bits = narrow_double(r.op);
        end else begin
          res.bits = double_to_integer(r.op, r.tgt, st);
          res.status = st;
        end
      end else begin
        case (r.src)
          SRC_I8:  v = {{56{r.op[7]}}, r.op[7:0]};
          SRC_I32: v = {{32{r.op[31]}}, r.op[31:0]};
          default: v = r.op;
        endcase
        if (r.tgt == TGT_F32) res.bits = signed_to_float(v, 1'b0);
        else if (r.tgt == TGT_F64) res.bits = signed_to_float(v, 1'b1);
        else res.bits = v & width_mask(8 * int'(tgt_size(r.tgt)));
      end
    end
    return res;
  endfunction

  function automatic dir_row_t row(input logic [1:0] s, input logic [3:0] t,
                                   input logic [63:0] op);
    dir_row_t d;
    d = '0;
    d.req = '{src: s, tgt: t, op: op};
    return d;
  endfunction

  function automatic dir_row_t fixed_row(input logic [1:0] s, input logic [3:0] t,
                                         input logic [63:0] op, input logic [63:0] bits,
                                         input logic [3:0] pop, input logic [3:0] push,
                                         input logic [1:0] st);
    dir_row_t d;
    d = row(s, t, op);
    d.has_fixed = 1'b1;
    d.fixed = '{bits: bits, popped: pop, pushed: push, status: st};
    return d;
  endfunction

  // Random operand, biased toward interesting float and integer patterns.
  function automatic logic [63:0] pick_operand(input logic [1:0] s);
    logic [63:0] op;
    logic [10:0] ex;
    op = {$urandom, $urandom};
    if (s == SRC_F64) begin
      case ($urandom_range(0, 5))
        0: ex = 11'd1023 + 11'($urandom_range(0, 66));
        1: ex = 11'd1023 - 11'($urandom_range(0, 40));
        2: ex = 11'd896 - 11'($urandom_range(0, 30));
        3: ex = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
        4: ex = 11'd1151 + 11'($urandom_range(0, 3));
        default: ex = op[62:52];
      endcase
      op[62:52] = ex;
      if ($urandom_range(0, 5) == 0) op[51:0] = $urandom_range(0, 1) ? 52'd0 : '1;
    end else begin
      case ($urandom_range(0, 4))
        0: op = op >> $urandom_range(0, 63);
        1: op = -(op >> $urandom_range(0, 63));
        default: ;
      endcase
    end
    return op;
  endfunction

  // Sender: drives at the falling edge and watches acceptance at the rising one.
  task automatic send_beat(input conv_req_t r);
    in_bus.source_type <= r.src;
    in_bus.target_type <= r.tgt;
    in_bus.operand_bits <= r.op;
    in_bus.valid <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(convert(r));
    @(negedge clk);
  endtask

  task automatic send_gap();
    int n;
    in_bus.valid <= 1'b0;
    n = $urandom_range(1, 4);
    repeat (n) @(negedge clk);
  endtask

  initial begin
    dir_row_t  d;
    conv_req_t r;
    int        burst;
    int        sent;

    in_bus.valid = 1'b0;
    in_bus.source_type = '0;
    in_bus.target_type = '0;
    in_bus.operand_bits = '0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_rows.push_back(fixed_row(SRC_I8, TGT_I16, 64'h80, 64'hFF80, 4'd1, 4'd2, ST_OK));
    dir_rows.push_back(fixed_row(SRC_I8, TGT_I16, 64'hFFFF_FFFF_FFFF_FF7F, 64'h7F, 4'd1,
                                 4'd2, ST_OK));
    dir_rows.push_back(fixed_row(SRC_I8, TGT_I32, 64'h12, 64'd0, 4'd0, 4'd0, ST_HALT));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_PTR, '1, 64'd0, 4'd0, 4'd0, ST_HALT));
    dir_rows.push_back(fixed_row(SRC_I32, 4'd15, '1, 64'd0, 4'd0, 4'd0, ST_HALT));
    dir_rows.push_back(fixed_row(SRC_I64, 4'd11, 64'd5, 64'd0, 4'd0, 4'd0, ST_HALT));
    dir_rows.push_back(fixed_row(SRC_I32, TGT_I32, '1, '1, 4'd0, 4'd0, ST_OK));
    dir_rows.push_back(fixed_row(SRC_I64, TGT_I64, 64'hDEAD_BEEF_0123_4567,
                                 64'hDEAD_BEEF_0123_4567, 4'd0, 4'd0, ST_OK));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_F64, 64'h7FF8_0000_0000_0001,
                                 64'h7FF8_0000_0000_0001, 4'd0, 4'd0, ST_OK));
    dir_rows.push_back(fixed_row(SRC_I32, TGT_PTR, 64'h8000_0000, 64'hFFFF_FFFF_8000_0000,
                                 4'd4, 4'd8, ST_OK));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_I32, 64'h7FF8_0000_0000_0000, 64'd0, 4'd8, 4'd4,
                                 ST_SAT));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_I8, 64'hFFF0_0000_0000_0000, 64'h80, 4'd8, 4'd1,
                                 ST_SAT));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_U64, 64'h7FF0_0000_0000_0000, '1, 4'd8, 4'd8,
                                 ST_SAT));
    dir_rows.push_back(fixed_row(SRC_F64, TGT_F32, 64'h7FF0_0000_0000_0000, 64'h7F80_0000,
                                 4'd8, 4'd4, ST_OK));
    dir_rows.push_back(fixed_row(SRC_I64, TGT_F64, 64'd0, 64'd0, 4'd8, 4'd8, ST_OK));
    // Computed rows: rounding, tiny values, negative to unsigned, wide integers.
    dir_rows.push_back(row(SRC_I64, TGT_F32, 64'h8000_0000_0000_0000));
    dir_rows.push_back(row(SRC_I64, TGT_F64, 64'h7FFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(row(SRC_I32, TGT_F32, 64'h0100_0003));
    dir_rows.push_back(row(SRC_F64, TGT_F32, 64'hFFF8_0000_2000_0000));
    dir_rows.push_back(row(SRC_F64, TGT_F32, 64'h3690_0000_0000_0001));
    dir_rows.push_back(row(SRC_F64, TGT_F32, 64'h47EF_FFFF_F000_0000));
    dir_rows.push_back(row(SRC_F64, TGT_U16, 64'hBFF8_0000_0000_0000));
    dir_rows.push_back(row(SRC_F64, TGT_U32, 64'hC000_0000_0000_0000));
    dir_rows.push_back(row(SRC_F64, TGT_I64, 64'hC3E0_0000_0000_0000));
    dir_rows.push_back(row(SRC_I64, TGT_U8, '1));

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      send_beat(d.req);
      // Typed-in rows replace the computed expectation with the table value.
      if (d.has_fixed) pending_results[$] = d.fixed;
    end
    send_gap();

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r.src = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0) r.tgt = 4'($urandom_range(0, 15));
        else if (r.src == SRC_I8 && $urandom_range(0, 3) != 0) r.tgt = TGT_I16;
        else r.tgt = 4'($urandom_range(0, 10));
        r.op = pick_operand(r.src);
        send_beat(r);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) send_gap();
      // Drain the pipeline completely once midway through.
      if (sent >= RANDOM_BEATS / 2 && sent < RANDOM_BEATS / 2 + burst) begin
        in_bus.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
    end
    in_bus.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: long open stretches mixed with choppy ones.
  initial begin
    int phase;
    out_bus.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 200 < 60) out_bus.ready <= 1'b1;
      else if (phase % 200 < 140) out_bus.ready <= ($urandom_range(0, 2) != 0);
      else out_bus.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Result checking at each rising edge with an accepted beat.
  always @(posedge clk) begin
    conv_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation: bits %h", out_bus.result_bits);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.result_bits !== want.bits) begin
          $error("result_bits expected %h got %h", want.bits, out_bus.result_bits);
          error_count++;
        end
        if (out_bus.popped_bytes !== want.popped) begin
          $error("popped_bytes expected %0d got %0d", want.popped, out_bus.popped_bytes);
          error_count++;
        end
        if (out_bus.pushed_bytes !== want.pushed) begin
          $error("pushed_bytes expected %0d got %0d", want.pushed, out_bus.pushed_bytes);
          error_count++;
        end
        if (out_bus.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_bus.status);
          error_count++;
        end
      end
    end
  end

  // End of run and the cycle watchdog.
  initial begin
    error_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done && pending_results.size() == 0);
        repeat (20) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        error_count++;
        $display("timeout after %0d cycles", cycle_count);
      end
    join_any
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_in_if.sv
hw/rtl/ntc_out_if.sv
hw/rtl/ntc_conv.sv
hw/rtl/numeric_type_converter.sv
hw/rtl/ntc_checker.sv
test/testbench.sv
